@@ src/jbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbc_pkg
// Opcodes, status codes, controller states and control structs shared by
// the bytecode execution core.
// ----------------------------------------------------------------------------
package jbc_pkg;

    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_5  = 8'h08;
    localparam logic [7:0] OP_ICONST_0  = 8'h03;
    localparam logic [7:0] OP_BIPUSH    = 8'h10;
    localparam logic [7:0] OP_SIPUSH    = 8'h11;
    localparam logic [7:0] OP_ILOAD     = 8'h15;
    localparam logic [7:0] OP_ALOAD     = 8'h19;
    localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
    localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
    localparam logic [7:0] OP_ALOAD_0   = 8'h2a;
    localparam logic [7:0] OP_ALOAD_3   = 8'h2d;
    localparam logic [7:0] OP_ISTORE    = 8'h36;
    localparam logic [7:0] OP_ASTORE    = 8'h3a;
    localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
    localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
    localparam logic [7:0] OP_ASTORE_0  = 8'h4b;
    localparam logic [7:0] OP_ASTORE_3  = 8'h4e;
    localparam logic [7:0] OP_DUP       = 8'h59;
    localparam logic [7:0] OP_IADD      = 8'h60;
    localparam logic [7:0] OP_ISUB      = 8'h64;
    localparam logic [7:0] OP_IMUL      = 8'h68;
    localparam logic [7:0] OP_IDIV      = 8'h6c;
    localparam logic [7:0] OP_IREM      = 8'h70;
    localparam logic [7:0] OP_INEG      = 8'h74;
    localparam logic [7:0] OP_ISHL      = 8'h78;
    localparam logic [7:0] OP_ISHR      = 8'h7a;
    localparam logic [7:0] OP_IUSHR     = 8'h7c;
    localparam logic [7:0] OP_IAND      = 8'h7e;
    localparam logic [7:0] OP_IOR       = 8'h80;
    localparam logic [7:0] OP_IXOR      = 8'h82;
    localparam logic [7:0] OP_IINC      = 8'h84;
    localparam logic [7:0] OP_IFEQ      = 8'h99;
    localparam logic [7:0] OP_IFNE      = 8'h9a;
    localparam logic [7:0] OP_IFLT      = 8'h9b;
    localparam logic [7:0] OP_IFGE      = 8'h9c;
    localparam logic [7:0] OP_IFGT      = 8'h9d;
    localparam logic [7:0] OP_IFLE      = 8'h9e;
    localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f;
    localparam logic [7:0] OP_IF_ICMPNE = 8'ha0;
    localparam logic [7:0] OP_IF_ICMPLT = 8'ha1;
    localparam logic [7:0] OP_IF_ICMPGE = 8'ha2;
    localparam logic [7:0] OP_IF_ICMPGT = 8'ha3;
    localparam logic [7:0] OP_IF_ICMPLE = 8'ha4;
    localparam logic [7:0] OP_GOTO      = 8'ha7;
    localparam logic [7:0] OP_GOTO_W    = 8'hc8;

    typedef enum logic [2:0] {
        STATUS_OK    = 3'd0,
        STATUS_UNSUP = 3'd1,
        STATUS_DIVZ  = 3'd2,
        STATUS_UNDER = 3'd3,
        STATUS_OVER  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } ctrl_stat_t;

endpackage

@@ src/jbc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbc_in_if / jbc_out_if
// Valid/ready channels for instructions and execution results.
// ----------------------------------------------------------------------------
interface jbc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opcode;
    logic [31:0] following_bytes;

    modport source (output valid, output opcode, output following_bytes, input ready);
    modport sink   (input valid, input opcode, input following_bytes, output ready);
endinterface

interface jbc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        next_pc;
    logic               branch_taken;
    logic signed [31:0] top_value;
    logic [6:0]         stack_count;

    modport source (output valid, output status, output next_pc, output branch_taken,
                    output top_value, output stack_count, input ready);
    modport sink   (input valid, input status, input next_pc, input branch_taken,
                    input top_value, input stack_count, output ready);
endinterface

@@ src/jbc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbc_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/jbc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbc_ctrl
// Sequencer: capture, execute, divide and commit of one instruction, and
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module jbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output jbc_pkg::ctrl_cmd_t cmd,
    input  jbc_pkg::ctrl_stat_t stat
);
    import jbc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.need_div)
                begin
                    state_next = S_DIV;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.div_start = stat.need_div;
                cmd.commit    = !stat.need_div && slot_free;
            end
            S_DIV:
            begin
                cmd.div_step = !stat.div_done;
            end
            S_DONE:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ src/jbc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbc_datapath
// Operand stack, locals, program counter, ALU, shift-subtract divider and
// the result register.
// ----------------------------------------------------------------------------
module jbc_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256,
    parameter int PC_WIDTH    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_opcode,
    input  logic [31:0]         in_following_bytes,
    input  jbc_pkg::ctrl_cmd_t  cmd,
    output jbc_pkg::ctrl_stat_t stat,
    output logic [2:0]          res_status,
    output logic [15:0]         res_next_pc,
    output logic                res_branch_taken,
    output logic signed [31:0]  res_top_value,
    output logic [6:0]          res_stack_count
);
    import jbc_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int LW  = $clog2(LOCAL_COUNT);

    logic [7:0]          op_reg;
    logic [31:0]         fb_reg;
    logic [SPW-1:0]      sp_reg;
    logic [PC_WIDTH-1:0] pc_reg;
    logic [31:0]         top_reg;
    logic [31:0]         rem_reg, quo_reg;
    logic [5:0]          cnt_reg;
    logic                div_busy_reg;

    logic [2:0]          status_reg;
    logic [15:0]         npc_reg;
    logic                br_reg;
    logic [31:0]         otop_reg;
    logic [6:0]          cnt_out_reg;

    // reduce an index byte modulo the local count, one bit a step
    function automatic logic [LW-1:0] lmod(input logic [7:0] v);
        logic [15:0] r;
        r = {8'd0, v};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (16'(LOCAL_COUNT) << k))
            begin
                r = r - (16'(LOCAL_COUNT) << k);
            end
        end
        return r[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] local_index(input logic [7:0] op, input logic [7:0] b1);
        logic [7:0] d;
        d = 8'd0;
        if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3)
        begin
            d = op - OP_ILOAD_0;
        end
        else if (op >= OP_ALOAD_0 && op <= OP_ALOAD_3)
        begin
            d = op - OP_ALOAD_0;
        end
        else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3)
        begin
            d = op - OP_ISTORE_0;
        end
        else if (op >= OP_ASTORE_0 && op <= OP_ASTORE_3)
        begin
            d = op - OP_ASTORE_0;
        end
        else
        begin
            return lmod(b1);
        end
        return LW'(d[1:0]);
    endfunction

    // ---------------- memories ----------------
    logic [SPW-1:0] sp_m2, sp_m3, sp_wr;
    logic [31:0]    st_rd0, st_rd1, loc_rd;
    logic           st_we, loc_we;
    logic [31:0]    res, loc_wdata;
    logic [LW-1:0]  loc_raddr, loc_addr;
    logic [1:0]     pops, pushes, len;

    assign sp_m2 = sp_reg - SPW'(2);
    assign sp_m3 = sp_reg - SPW'(3);
    assign sp_wr = sp_reg - SPW'(pops) + SPW'(pushes) - SPW'(1);

    assign loc_addr  = local_index(op_reg, fb_reg[31:24]);
    assign loc_raddr = cmd.capture ? local_index(in_opcode, in_following_bytes[31:24])
                                   : loc_addr;

    jbc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack0 (
        .clk   (clk),
        .we    (st_we),
        .waddr (sp_wr[SW-1:0]),
        .wdata (res),
        .raddr (sp_m2[SW-1:0]),
        .rdata (st_rd0)
    );

    // mirror copy gives the entry below the second one
    jbc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack1 (
        .clk   (clk),
        .we    (st_we),
        .waddr (sp_wr[SW-1:0]),
        .wdata (res),
        .raddr (sp_m3[SW-1:0]),
        .rdata (st_rd1)
    );

    jbc_ram #(.WIDTH(32), .DEPTH(LOCAL_COUNT)) u_locals (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_addr),
        .wdata (loc_wdata),
        .raddr (loc_raddr),
        .rdata (loc_rd)
    );

    // ---------------- decode ----------------
    logic supp, is_load, is_store, is_div;
    logic [7:0] op;
    assign op = op_reg;

    always_comb
    begin
        supp     = 1'b1;
        pops     = 2'd0;
        pushes   = 2'd0;
        len      = 2'd1;
        is_load  = 1'b0;
        is_store = 1'b0;
        priority if (op == OP_NOP || op == OP_GOTO || op == OP_GOTO_W)
        begin
            supp = 1'b1;
        end
        else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5)
        begin
            pushes = 2'd1;
        end
        else if (op == OP_BIPUSH)
        begin
            pushes = 2'd1;
            len    = 2'd2;
        end
        else if (op == OP_SIPUSH)
        begin
            pushes = 2'd1;
            len    = 2'd3;
        end
        else if (op == OP_ILOAD || op == OP_ALOAD)
        begin
            pushes  = 2'd1;
            len     = 2'd2;
            is_load = 1'b1;
        end
        else if ((op >= OP_ILOAD_0 && op <= OP_ILOAD_3) ||
                 (op >= OP_ALOAD_0 && op <= OP_ALOAD_3))
        begin
            pushes  = 2'd1;
            is_load = 1'b1;
        end
        else if (op == OP_ISTORE || op == OP_ASTORE)
        begin
            pops     = 2'd1;
            len      = 2'd2;
            is_store = 1'b1;
        end
        else if ((op >= OP_ISTORE_0 && op <= OP_ISTORE_3) ||
                 (op >= OP_ASTORE_0 && op <= OP_ASTORE_3))
        begin
            pops     = 2'd1;
            is_store = 1'b1;
        end
        else if (op == OP_DUP)
        begin
            pops   = 2'd1;
            pushes = 2'd2;
        end
        else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV ||
                 op == OP_IREM || op == OP_ISHL || op == OP_ISHR || op == OP_IUSHR ||
                 op == OP_IAND || op == OP_IOR || op == OP_IXOR)
        begin
            pops   = 2'd2;
            pushes = 2'd1;
        end
        else if (op == OP_INEG)
        begin
            pops   = 2'd1;
            pushes = 2'd1;
        end
        else if (op == OP_IINC)
        begin
            len = 2'd3;
        end
        else if (op >= OP_IFEQ && op <= OP_IFLE)
        begin
            pops = 2'd1;
            len  = 2'd3;
        end
        else if (op >= OP_IF_ICMPEQ && op <= OP_IF_ICMPLE)
        begin
            pops = 2'd2;
            len  = 2'd3;
        end
        else
        begin
            supp = 1'b0;
        end
    end

    assign is_div = (op == OP_IDIV) || (op == OP_IREM);

    // ---------------- execute ----------------
    logic [31:0] a, b, third;
    logic [7:0]  b1, b2, cdelta;
    logic [31:0] sext_b1, sext_b2, off16;
    status_t     status;
    logic        grow;

    assign b     = top_reg;
    assign a     = st_rd0;
    assign third = st_rd1;
    assign b1    = fb_reg[31:24];
    assign b2    = fb_reg[23:16];
    assign sext_b1 = {{24{b1[7]}}, b1};
    assign sext_b2 = {{24{b2[7]}}, b2};
    assign off16   = {{16{fb_reg[31]}}, fb_reg[31:16]};
    assign cdelta  = op - OP_ICONST_0;
    assign grow    = (pushes == 2'd1 && pops == 2'd0) || pushes == 2'd2;

    always_comb
    begin
        priority if (!supp)
        begin
            status = STATUS_UNSUP;
        end
        else if (sp_reg < SPW'(pops))
        begin
            status = STATUS_UNDER;
        end
        else if (grow && sp_reg == SPW'(STACK_DEPTH))
        begin
            status = STATUS_OVER;
        end
        else if (is_div && b == 32'd0)
        begin
            status = STATUS_DIVZ;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign stat.need_div = is_div && status == STATUS_OK && cnt_reg == 6'd0 && !div_busy_reg;
    assign stat.div_done = cnt_reg == 6'd32;

    // divider magnitudes and signs
    logic [31:0] ma, mb, q_s, r_s;
    logic [32:0] trial;

    assign ma    = a[31] ? 32'd0 - a : a;
    assign mb    = b[31] ? 32'd0 - b : b;
    assign q_s   = (a[31] != b[31]) ? 32'd0 - quo_reg : quo_reg;
    assign r_s   = a[31] ? 32'd0 - rem_reg : rem_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, mb};

    always_comb
    begin
        res = 32'd0;
        priority if (op >= OP_ICONST_M1 && op <= OP_ICONST_5)
        begin
            res = {{24{cdelta[7]}}, cdelta};
        end
        else if (op == OP_BIPUSH)
        begin
            res = sext_b1;
        end
        else if (op == OP_SIPUSH)
        begin
            res = off16;
        end
        else if (is_load)
        begin
            res = loc_rd;
        end
        else if (op == OP_DUP)
        begin
            res = b;
        end
        else if (op == OP_IADD)
        begin
            res = a + b;
        end
        else if (op == OP_ISUB)
        begin
            res = a - b;
        end
        else if (op == OP_IMUL)
        begin
            res = a * b;
        end
        else if (op == OP_IDIV)
        begin
            res = q_s;
        end
        else if (op == OP_IREM)
        begin
            res = r_s;
        end
        else if (op == OP_INEG)
        begin
            res = 32'd0 - b;
        end
        else if (op == OP_ISHL)
        begin
            res = a << b[4:0];
        end
        else if (op == OP_ISHR)
        begin
            res = 32'($signed(a) >>> b[4:0]);
        end
        else if (op == OP_IUSHR)
        begin
            res = a >> b[4:0];
        end
        else if (op == OP_IAND)
        begin
            res = a & b;
        end
        else if (op == OP_IOR)
        begin
            res = a | b;
        end
        else if (op == OP_IXOR)
        begin
            res = a ^ b;
        end
        else
        begin
            res = 32'd0;
        end
    end

    logic jump;
    always_comb
    begin
        unique case (op)
            OP_IFEQ:      jump = b == 32'd0;
            OP_IFNE:      jump = b != 32'd0;
            OP_IFLT:      jump = b[31];
            OP_IFGE:      jump = !b[31];
            OP_IFGT:      jump = b != 32'd0 && !b[31];
            OP_IFLE:      jump = b == 32'd0 || b[31];
            OP_IF_ICMPEQ: jump = a == b;
            OP_IF_ICMPNE: jump = a != b;
            OP_IF_ICMPLT: jump = $signed(a) < $signed(b);
            OP_IF_ICMPGE: jump = !($signed(a) < $signed(b));
            OP_IF_ICMPGT: jump = $signed(b) < $signed(a);
            OP_IF_ICMPLE: jump = !($signed(b) < $signed(a));
            OP_GOTO:      jump = 1'b1;
            OP_GOTO_W:    jump = 1'b1;
            default:      jump = 1'b0;
        endcase
    end

    logic [31:0]          pc_sum, step, new_top, pc_ok_ext, pc_hold_ext;
    logic [PC_WIDTH-1:0]  pc_new;
    logic [SPW-1:0]       sp_new;
    logic                 ok;

    assign ok          = status == STATUS_OK;
    assign step        = jump ? ((op == OP_GOTO_W) ? fb_reg : off16) : 32'(len);
    assign pc_sum      = 32'(pc_reg) + step;
    assign pc_new      = pc_sum[PC_WIDTH-1:0];
    assign sp_new      = sp_reg - SPW'(pops) + SPW'(pushes);
    assign pc_ok_ext   = 32'(pc_new);
    assign pc_hold_ext = 32'(pc_reg);

    always_comb
    begin
        unique case (pops)
            2'd1:    new_top = a;
            2'd2:    new_top = third;
            default: new_top = b;
        endcase
        if (pushes != 2'd0)
        begin
            new_top = res;
        end
    end

    assign st_we     = cmd.commit && ok && pushes != 2'd0;
    assign loc_we    = cmd.commit && ok && (is_store || op == OP_IINC);
    assign loc_wdata = is_store ? b : loc_rd + sext_b2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg       <= '0;
            pc_reg       <= '0;
            cnt_reg      <= '0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                cnt_reg      <= '0;
                div_busy_reg <= 1'b1;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (cmd.commit)
            begin
                cnt_reg      <= '0;
                div_busy_reg <= 1'b0;
                if (ok)
                begin
                    sp_reg <= sp_new;
                    pc_reg <= pc_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_opcode;
            fb_reg <= in_following_bytes;
        end
        if (cmd.div_start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= ma;
        end
        else if (cmd.div_step)
        begin
            // shift in one dividend bit, subtract where it fits
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            status_reg <= status;
            br_reg     <= ok && jump;
            if (ok)
            begin
                top_reg     <= new_top;
                npc_reg     <= pc_ok_ext[15:0];
                otop_reg    <= (sp_new != '0) ? new_top : 32'd0;
                cnt_out_reg <= 7'(sp_new);
            end
            else
            begin
                npc_reg     <= pc_hold_ext[15:0];
                otop_reg    <= (sp_reg != '0) ? top_reg : 32'd0;
                cnt_out_reg <= 7'(sp_reg);
            end
        end
    end

    assign res_status       = status_reg;
    assign res_next_pc      = npc_reg;
    assign res_branch_taken = br_reg;
    assign res_top_value    = otop_reg;
    assign res_stack_count  = cnt_out_reg;
endmodule

@@ src/java_int_bytecode_execution_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// java_int_bytecode_execution_core
// Integer bytecode interpreter core: one instruction in, one result out.
// ----------------------------------------------------------------------------
// Each instruction is captured in S_IDLE, which also addresses the operand
// stack and local RAMs, whose read data is registered, then executed and
// committed in S_EXEC; idiv and irem run the 32-step shift-subtract divider
// in S_DIV and commit in S_DONE. Commit waits while the output register
// holds an unaccepted result. A finished result waits there while the next
// instruction is captured. The stack and local RAMs need no clearing pass;
// stack entries are only read below the stack pointer.
module java_int_bytecode_execution_core #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256,
    parameter int PC_WIDTH    = 16
) (
    input  logic clk,
    input  logic rst_n,
    jbc_in_if.sink    instr,
    jbc_out_if.source result
);
    import jbc_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    jbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (instr.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    jbc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOCAL_COUNT (LOCAL_COUNT),
        .PC_WIDTH    (PC_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_opcode          (instr.opcode),
        .in_following_bytes (instr.following_bytes),
        .cmd                (cmd),
        .stat               (stat),
        .res_status         (result.status),
        .res_next_pc        (result.next_pc),
        .res_branch_taken   (result.branch_taken),
        .res_top_value      (result.top_value),
        .res_stack_count    (result.stack_count)
    );
endmodule

@@ tb/jbc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbc_checker
// Watches the instruction and result channels, runs a cycle-free model of
// the interpreter on each accepted instruction and compares every result.
// ----------------------------------------------------------------------------
module jbc_checker
    import jbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    jbc_in_if.sink    instr,
    jbc_out_if.sink   result,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] next_pc;
        logic        branch_taken;
        logic [31:0] top_value;
        logic [6:0]  stack_count;
    } exec_result_t;

    logic [31:0]  opstack [64];
    logic [31:0]  locals [256];
    int           sp;
    logic [15:0]  pc;
    exec_result_t result_q[$];

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic exec_result_t make_res(input logic [2:0] st, input logic br);
        exec_result_t r;
        r.status = st;
        r.next_pc = pc;
        r.branch_taken = br;
        r.top_value = (sp > 0) ? opstack[sp-1] : 32'd0;
        r.stack_count = sp[6:0];
        return r;
    endfunction

    function automatic exec_result_t execute(input logic [7:0] op, input logic [31:0] fb);
        int pops, pushes, len;
        logic [31:0] a, b, res, joff, ma, mb, mq, mr;
        logic [7:0] b1, b2;
        logic jump, known;
        pops = 0; pushes = 0; len = 1; a = 0; b = 0; res = 0; jump = 0; known = 1;
        b1 = fb[31:24]; b2 = fb[23:16];
        if (op == OP_NOP || op == OP_GOTO || op == OP_GOTO_W) ;
        else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) pushes = 1;
        else if (op == OP_BIPUSH || op == OP_ILOAD || op == OP_ALOAD)
        begin
            pushes = 1; len = 2;
        end
        else if (op == OP_SIPUSH)
        begin
            pushes = 1; len = 3;
        end
        else if ((op >= OP_ILOAD_0 && op <= OP_ILOAD_3) ||
                 (op >= OP_ALOAD_0 && op <= OP_ALOAD_3)) pushes = 1;
        else if (op == OP_ISTORE || op == OP_ASTORE)
        begin
            pops = 1; len = 2;
        end
        else if ((op >= OP_ISTORE_0 && op <= OP_ISTORE_3) ||
                 (op >= OP_ASTORE_0 && op <= OP_ASTORE_3)) pops = 1;
        else if (op == OP_DUP)
        begin
            pops = 1; pushes = 2;
        end
        else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV ||
                 op == OP_IREM || op == OP_ISHL || op == OP_ISHR || op == OP_IUSHR ||
                 op == OP_IAND || op == OP_IOR || op == OP_IXOR)
        begin
            pops = 2; pushes = 1;
        end
        else if (op == OP_INEG)
        begin
            pops = 1; pushes = 1;
        end
        else if (op == OP_IINC) len = 3;
        else if (op >= OP_IFEQ && op <= OP_IFLE)
        begin
            pops = 1; len = 3;
        end
        else if (op >= OP_IF_ICMPEQ && op <= OP_IF_ICMPLE)
        begin
            pops = 2; len = 3;
        end
        else known = 0;
        if (!known) return make_res(STATUS_UNSUP, 1'b0);
        if (sp < pops) return make_res(STATUS_UNDER, 1'b0);
        if (sp - pops + pushes > 64) return make_res(STATUS_OVER, 1'b0);
        if (pops >= 1) b = opstack[sp-1];
        if (pops >= 2) a = opstack[sp-2];
        if ((op == OP_IDIV || op == OP_IREM) && b == 0) return make_res(STATUS_DIVZ, 1'b0);
        case (op)
            OP_BIPUSH: res = sx8(b1);
            OP_SIPUSH: res = {{16{fb[31]}}, fb[31:16]};
            OP_ILOAD, OP_ALOAD: res = locals[b1];
            OP_ISTORE, OP_ASTORE: locals[b1] = b;
            OP_DUP: res = b;
            OP_IADD: res = a + b;
            OP_ISUB: res = a - b;
            OP_IMUL: res = a * b;
            OP_IDIV, OP_IREM:
            begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                mq = ma / mb; mr = ma % mb;
                res = (op == OP_IDIV) ? ((a[31] != b[31]) ? -mq : mq) : (a[31] ? -mr : mr);
            end
            OP_INEG: res = -b;
            OP_ISHL: res = a << b[4:0];
            OP_ISHR: res = $signed(a) >>> b[4:0];
            OP_IUSHR: res = a >> b[4:0];
            OP_IAND: res = a & b;
            OP_IOR: res = a | b;
            OP_IXOR: res = a ^ b;
            OP_IINC: locals[b1] = locals[b1] + sx8(b2);
            OP_IFEQ: jump = (b == 0);
            OP_IFNE: jump = (b != 0);
            OP_IFLT: jump = b[31];
            OP_IFGE: jump = !b[31];
            OP_IFGT: jump = (b != 0) && !b[31];
            OP_IFLE: jump = (b == 0) || b[31];
            OP_IF_ICMPEQ: jump = (a == b);
            OP_IF_ICMPNE: jump = (a != b);
            OP_IF_ICMPLT: jump = $signed(a) < $signed(b);
            OP_IF_ICMPGE: jump = $signed(a) >= $signed(b);
            OP_IF_ICMPGT: jump = $signed(a) > $signed(b);
            OP_IF_ICMPLE: jump = $signed(a) <= $signed(b);
            OP_GOTO, OP_GOTO_W: jump = 1;
            default:
            begin
                if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) res = op - 8'd3 | {32{op == OP_ICONST_M1}};
                else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3) res = locals[op - OP_ILOAD_0];
                else if (op >= OP_ALOAD_0 && op <= OP_ALOAD_3) res = locals[op - OP_ALOAD_0];
                else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) locals[op - OP_ISTORE_0] = b;
                else if (op >= OP_ASTORE_0 && op <= OP_ASTORE_3) locals[op - OP_ASTORE_0] = b;
            end
        endcase
        joff = (op == OP_GOTO_W) ? fb : {{16{fb[31]}}, fb[31:16]};
        sp = sp - pops;
        if (pushes == 2) opstack[sp++] = b;
        if (pushes >= 1) opstack[sp++] = res;
        pc = jump ? pc + joff[15:0] : pc + len[15:0];
        return make_res(STATUS_OK, jump);
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t e;
        exec_result_t got;
        if (!rst_n)
        begin
            sp = 0;
            pc = '0;
            fail_count <= 0;
            result_q.delete();
        end
        else
        begin
            if (instr.valid && instr.ready)
                result_q.push_back(execute(instr.opcode, instr.following_bytes));
            if (result.valid && result.ready)
            begin
                got = {result.status, result.next_pc, result.branch_taken,
                       result.top_value, result.stack_count};
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (e !== got)
                    begin
                        $display("%0t: mismatch exp st=%0d pc=%h br=%b top=%h cnt=%0d",
                                 $time, e.status, e.next_pc, e.branch_taken, e.top_value,
                                 e.stack_count);
                        $display("%0t:          act st=%0d pc=%h br=%b top=%h cnt=%0d",
                                 $time, got.status, got.next_pc, got.branch_taken,
                                 got.top_value, got.stack_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random bytecode streams into the interpreter core
// under varying back-pressure, then reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import jbc_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   recv_idle;
    int   hold_off;
    int   quiet;
    bit   written [256];
    int   model_sp;

    jbc_in_if  instr ();
    jbc_out_if result ();

    java_int_bytecode_execution_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr.sink),
        .result (result.source)
    );

    jbc_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr.sink),
        .result     (result.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls plus a long hold-off when requested
    initial
    begin
        result.ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                result.ready <= 0;
            end
            else
                result.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((instr.valid && instr.ready) || (result.valid && result.ready)) quiet = 0;
            else quiet++;
            if (quiet > 20000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // valid stays high into the next transaction; idle cycles drop it
    task automatic send(input logic [7:0] op, input logic [31:0] fb);
        while ($urandom_range(99) < send_idle)
        begin
            instr.valid <= 0;
            @(posedge clk);
        end
        instr.valid <= 1;
        instr.opcode <= op;
        instr.following_bytes <= fb;
        @(posedge clk);
        while (!instr.ready) @(posedge clk);
    endtask

    // pick an instruction that keeps the stack sane and reads only written locals;
    // model_sp may lag by one transaction, which pops at most two entries
    task automatic send_random();
        logic [7:0] op;
        logic [31:0] fb;
        int k, idx;
        fb = $urandom();
        k = $urandom_range(99);
        if (k < 5) op = 8'($urandom_range(255));
        else if (model_sp < 3 || k < 30)
        begin
            case ($urandom_range(3))
                0: op = OP_BIPUSH;
                1: op = OP_SIPUSH;
                2: op = 8'($urandom_range(OP_ICONST_M1, OP_ICONST_5));
                default: op = OP_DUP;
            endcase
        end
        else if (model_sp > 50 && k < 60) op = OP_ISTORE;
        else
        begin
            case ($urandom_range(7))
                0, 1: op = 8'(8'h60 + 4 * $urandom_range(0, 8));
                2: op = 8'(8'h78 + 2 * $urandom_range(0, 5));
                3: op = OP_INEG;
                4: op = 8'($urandom_range(OP_IFEQ, OP_IF_ICMPLE));
                5: op = $urandom_range(0, 1) ? OP_GOTO : OP_GOTO_W;
                6: op = $urandom_range(0, 1) ? OP_ISTORE
                                             : 8'($urandom_range(OP_ISTORE_0, OP_ISTORE_3));
                default: op = $urandom_range(0, 2) == 0 ? OP_IINC : OP_ILOAD;
            endcase
        end
        idx = int'(fb[31:24]);
        if (op == OP_ILOAD || op == OP_ALOAD || op == OP_IINC)
            if (!written[idx]) op = OP_NOP;
        if ((op >= OP_ILOAD_0 && op <= OP_ILOAD_3 && !written[op - OP_ILOAD_0]) ||
            (op >= OP_ALOAD_0 && op <= OP_ALOAD_3 && !written[op - OP_ALOAD_0]))
            op = OP_NOP;
        if (model_sp > 2 && (op == OP_ISTORE || op == OP_ASTORE)) written[idx] = 1;
        if (model_sp > 2 && op >= OP_ISTORE_0 && op <= OP_ISTORE_3) written[op - OP_ISTORE_0] = 1;
        if (model_sp > 2 && op >= OP_ASTORE_0 && op <= OP_ASTORE_3) written[op - OP_ASTORE_0] = 1;
        send(op, fb);
        model_sp = chk.sp;
    endtask

    initial
    begin
        int n;
        rst_n = 0;
        instr.valid = 0;
        instr.opcode = 0;
        instr.following_bytes = 0;
        hold_off = 0;
        send_idle = 18;
        recv_idle = 81;
        model_sp = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: underflow, extremes, special cases
        send(OP_IADD, 0);
        send(OP_ICONST_M1, 0);
        send(OP_BIPUSH, 32'h80ff_ffff);
        send(OP_SIPUSH, 32'h8000_0000);
        send(OP_SIPUSH, 32'h7fff_0000);
        send(OP_ISTORE, 32'hff00_0000);
        send(OP_ILOAD, 32'hff00_0000);
        send(OP_IINC, 32'hff80_0000);
        send(OP_ALOAD, 32'hff00_0000);
        send(OP_ICONST_0, 0);
        send(OP_IDIV, 0);
        send(OP_IREM, 0);
        send(OP_SIPUSH, 32'h8000_0000);
        send(OP_BIPUSH, 32'h1000_0000);
        send(OP_ISHL, 0);
        send(OP_ICONST_M1, 0);
        send(OP_IDIV, 0);
        send(OP_DUP, 0);
        send(OP_ICONST_M1, 0);
        send(OP_IREM, 0);
        send(OP_IFEQ, 32'h8000_0000);
        send(OP_GOTO_W, 32'hffff_ffff);
        send(8'hff, 32'hffff_ffff);
        for (int i = 0; i < 4; i++) written[i] = 0;
        written[255] = 1;
        model_sp = chk.sp;
        for (n = 0; n < 1700; n++)
        begin
            if (n == 600)
            begin
                send_idle = 81;
                recv_idle = 18;
            end
            if (n == 1000) hold_off = 300;
            if (n == 1200)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n == 1400) hold_off = 200;
            // fill toward overflow once, at iteration 1500
            if (n == 1500) for (int j = 0; j < 70; j++) send(OP_ICONST_5, 0);
            send_random();
        end
        instr.valid <= 0;
        while (pending > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
src/jbc_pkg.sv
src/jbc_if.sv
src/jbc_ram.sv
src/jbc_ctrl.sv
src/jbc_datapath.sv
src/java_int_bytecode_execution_core.sv
tb/jbc_checker.sv
tb/tb_top.sv
